>>> sv/crbs_pkg.sv
// Package for the crash-restart backoff supervisor: widths, codes, shared structs,
// and the microprogram ROM with its opcode dispatch map.
// No dependencies; every other file in sv/ imports this package.
package crbs_pkg;

  // Field widths of the stream items and the configuration port.
  localparam int TIME_BITS   = 48;
  localparam int COUNT_BITS  = 8;
  localparam int NOW_W       = 48;
  localparam int GEN_W       = 64;
  localparam int CNT_W       = COUNT_BITS;
  localparam int V_W         = 32;
  localparam int MULT_W      = 16;
  localparam int Q_FRAC      = 8;
  localparam int BO_W        = 24;
  localparam int RD_W        = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 104;

  // Times are kept to TIME_BITS bits.
  localparam int TIME_KEEP = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam logic [NOW_W-1:0] TIME_MASK = {NOW_W{1'b1}} >> (NOW_W - TIME_KEEP);
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    M_IDLE, M_WATCH, M_RECON, M_BACKOFF, M_TERM
  } mode_e;

  typedef enum logic [1:0] {
    R_NONE, R_TERMINAL, R_BACKOFF, R_RESTARTED
  } res_code_e;

  typedef enum logic [2:0] {
    OP_BEGIN, OP_STOP, OP_CHECK, OP_SHUTDOWN, OP_STABLE, OP_CRASH, OP_QUERY, OP_NONE
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RESTARTS, CFG_BASE_BACKOFF, CFG_MULT_Q8, CFG_MAX_BACKOFF, CFG_STABLE_IVL
  } cfg_reg_e;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    U_NOP, U_BEGIN, U_STOP, U_SHUT, U_STABLE, U_RCRASH, U_CHECK, U_BSET_CUR,
    U_BSET_PREV, U_MUL, U_CAP, U_QUERY, U_DECIDE, U_INC, U_TERM, U_FIN
  } uop_e;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_NOT_CRASH, C_OVER_BUDGET, C_K_GT1, C_NOT_BACKOFF, C_OUT_BUSY
  } cond_e;

  localparam int STEP_W      = 5;
  localparam int UCODE_DEPTH = 23;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;
  } ucw_t;

  typedef struct packed {
    logic [7:0]  max_restarts;
    logic [15:0] base_backoff;
    logic [15:0] mult_q8;
    logic [23:0] max_backoff;
    logic [31:0] stable_ivl;
  } cfg_t;

  typedef struct packed {
    logic [IN_TUSER_W-1:0] opcode;
    logic [GEN_W-1:0]      generation;
    logic [NOW_W-1:0]      now_ms;
    logic                  crashed;
    logic                  restart_ok;
  } item_t;

  typedef struct packed {
    res_code_e        code;
    logic             invalidate;
    logic [GEN_W-1:0] inv_gen;
    logic             do_shutdown;
    logic             answer;
    mode_e            fsm_state;
    logic [RD_W-1:0]  restarts_done;
    logic [BO_W-1:0]  current_backoff;
  } result_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic accept;
    uop_e op;
  } ctrl_t;

  // Datapath to sequencer: branch flags.
  typedef struct packed {
    logic not_crash;
    logic over_budget;
    logic k_gt1;
    logic not_backoff;
  } stat_t;

  // Entry points and loop heads of the microprogram.
  localparam step_t S_BEGIN  = step_t'(0);
  localparam step_t S_STOP   = step_t'(1);
  localparam step_t S_SHUT   = step_t'(2);
  localparam step_t S_STABLE = step_t'(3);
  localparam step_t S_RCRASH = step_t'(4);
  localparam step_t S_QUERY  = step_t'(5);
  localparam step_t S_QLOOP  = step_t'(7);
  localparam step_t S_CHECK  = step_t'(10);
  localparam step_t S_CLOOP  = step_t'(14);
  localparam step_t S_TERM   = step_t'(18);
  localparam step_t S_TAIL   = step_t'(19);
  localparam step_t S_TLOOP  = step_t'(20);
  localparam step_t S_FIN    = step_t'(22);

  // A jump is taken after the step's operation when its condition holds on
  // the registers as they stood at the start of the step.
  localparam ucw_t UCODE [UCODE_DEPTH] = '{
    '{U_BEGIN,     C_ALWAYS,      S_TAIL },  // begin watch
    '{U_STOP,      C_ALWAYS,      S_TAIL },  // stop
    '{U_SHUT,      C_ALWAYS,      S_TAIL },  // shutdown request
    '{U_STABLE,    C_ALWAYS,      S_TAIL },  // mark stable
    '{U_RCRASH,    C_ALWAYS,      S_TAIL },  // record crash
    '{U_NOP,       C_NOT_BACKOFF, S_TAIL },  // backoff query
    '{U_BSET_PREV, C_NEXT,        S_TAIL },
    '{U_MUL,       C_K_GT1,       S_QLOOP},
    '{U_CAP,       C_NEXT,        S_TAIL },
    '{U_QUERY,     C_ALWAYS,      S_TAIL },
    '{U_NOP,       C_NOT_CRASH,   S_TAIL },  // crash check
    '{U_CHECK,     C_NEXT,        S_TAIL },
    '{U_NOP,       C_OVER_BUDGET, S_TERM },
    '{U_BSET_CUR,  C_NEXT,        S_TAIL },
    '{U_MUL,       C_K_GT1,       S_CLOOP},
    '{U_CAP,       C_NEXT,        S_TAIL },
    '{U_DECIDE,    C_NEXT,        S_TAIL },
    '{U_INC,       C_ALWAYS,      S_TAIL },
    '{U_TERM,      C_NEXT,        S_TAIL },  // budget spent
    '{U_BSET_CUR,  C_NEXT,        S_TAIL },  // common tail: reported backoff
    '{U_MUL,       C_K_GT1,       S_TLOOP},
    '{U_CAP,       C_NEXT,        S_TAIL },
    '{U_FIN,       C_OUT_BUSY,    S_FIN  }
  };

  function automatic step_t dispatch(logic [IN_TUSER_W-1:0] opcode);
    step_t s;
    unique case (opcode)
      OP_BEGIN:    s = S_BEGIN;
      OP_STOP:     s = S_STOP;
      OP_CHECK:    s = S_CHECK;
      OP_SHUTDOWN: s = S_SHUT;
      OP_STABLE:   s = S_STABLE;
      OP_CRASH:    s = S_RCRASH;
      OP_QUERY:    s = S_QUERY;
      default:     s = S_TAIL;
    endcase
    return s;
  endfunction

endpackage

>>> sv/crbs_useq.sv
// Microprogram sequencer of the crash-restart backoff supervisor: step counter,
// ROM readout and conditional jumps. Depends on crbs_pkg.
module crbs_useq import crbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [IN_TUSER_W-1:0] opcode_i,
  input  logic                  out_busy_i,
  input  stat_t                 stat_i,
  output ctrl_t                 ctrl_o
);

  logic  run_q, run_d;
  step_t step_q, step_d;
  ucw_t  cw;
  logic  jump;
  logic  accept;

  assign cw         = UCODE[step_q];
  assign in_ready_o = !run_q;
  assign accept     = in_valid_i && !run_q;

  always_comb begin
    unique case (cw.cond)
      C_NEXT:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NOT_CRASH:   jump = stat_i.not_crash;
      C_OVER_BUDGET: jump = stat_i.over_budget;
      C_K_GT1:       jump = stat_i.k_gt1;
      C_NOT_BACKOFF: jump = stat_i.not_backoff;
      C_OUT_BUSY:    jump = out_busy_i;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    run_d         = run_q;
    step_d        = step_q;
    ctrl_o.accept = accept;
    ctrl_o.op     = U_NOP;
    if (accept) begin
      run_d  = 1'b1;
      step_d = dispatch(opcode_i);
    end else if (run_q) begin
      // The result hand-off waits while the output register still holds one.
      if (cw.op == U_FIN && out_busy_i) begin
        ctrl_o.op = U_NOP;
      end else begin
        ctrl_o.op = cw.op;
      end
      if (cw.op == U_FIN && !out_busy_i) begin
        run_d = 1'b0;
      end else begin
        step_d = jump ? cw.target : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

endmodule

>>> sv/crbs_dpath.sv
// Datapath of the crash-restart backoff supervisor: supervisor state, the
// iterated Q8.8 backoff multiplier and the result fields. Depends on crbs_pkg.
module crbs_dpath import crbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctrl_t   ctrl_i,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  output stat_t   stat_o,
  output result_t res_o
);

  // Latched event and scratch registers.
  item_t           it_q, it_d;
  logic [V_W-1:0]  v_q, v_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic            z_q, z_d;
  logic [BO_W-1:0] b_q, b_d;

  // Supervisor state.
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic             grace_q, grace_d;
  logic [NOW_W-1:0] lct_q, lct_d;
  logic [NOW_W-1:0] lst_q, lst_d;

  // Result fields of the event in progress.
  res_code_e        code_q, code_d;
  logic             inval_q, inval_d;
  logic [GEN_W-1:0] ig_q, ig_d;
  logic             shut_q, shut_d;
  logic             ans_q, ans_d;

  logic [V_W+MULT_W-1:0]      prod;
  logic [V_W+MULT_W-Q_FRAC-1:0] prod_sh;
  logic [V_W-1:0]             v_next;
  logic [NOW_W:0]             d_stable;
  logic [NOW_W:0]             d_crash;
  logic                       stable_ok;
  logic                       query_ok;
  logic [CNT_W-1:0]           cnt_prev;
  logic [15:0]                cnt_wide;

  assign prod    = v_q * cfg_i.mult_q8;
  assign prod_sh = prod[V_W+MULT_W-1:Q_FRAC];
  // Saturate the truncated product at the all-ones 32-bit value.
  assign v_next  = (|prod_sh[V_W+MULT_W-Q_FRAC-1:V_W]) ? {V_W{1'b1}} : prod_sh[V_W-1:0];

  // A time earlier than the reference never counts as elapsed.
  assign d_stable  = {1'b0, it_q.now_ms} - {1'b0, lst_q};
  assign stable_ok = !d_stable[NOW_W] && (d_stable[NOW_W-1:0] >= NOW_W'(cfg_i.stable_ivl));
  assign d_crash   = {1'b0, it_q.now_ms} - {1'b0, lct_q};
  assign query_ok  = !d_crash[NOW_W] && (d_crash[NOW_W-1:0] >= NOW_W'(b_q));

  assign cnt_prev = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
  assign cnt_wide = 16'(cnt_q);

  assign stat_o.not_crash   = !(mode_q == M_WATCH && it_q.crashed);
  assign stat_o.over_budget = cnt_wide >= 16'(cfg_i.max_restarts);
  assign stat_o.k_gt1       = k_q > CNT_W'(1);
  assign stat_o.not_backoff = mode_q != M_BACKOFF;

  assign res_o.code            = code_q;
  assign res_o.invalidate      = inval_q;
  assign res_o.inv_gen         = ig_q;
  assign res_o.do_shutdown     = shut_q;
  assign res_o.answer          = ans_q;
  assign res_o.fsm_state       = mode_q;
  assign res_o.restarts_done   = (cnt_wide > 16'd255) ? {RD_W{1'b1}} : cnt_wide[RD_W-1:0];
  assign res_o.current_backoff = b_q;

  always_comb begin
    it_d    = it_q;
    v_d     = v_q;
    k_d     = k_q;
    z_d     = z_q;
    b_d     = b_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    gen_d   = gen_q;
    grace_d = grace_q;
    lct_d   = lct_q;
    lst_d   = lst_q;
    code_d  = code_q;
    inval_d = inval_q;
    ig_d    = ig_q;
    shut_d  = shut_q;
    ans_d   = ans_q;

    if (ctrl_i.accept) begin
      it_d        = item_i;
      it_d.now_ms = item_i.now_ms & TIME_MASK;
      code_d      = R_NONE;
      inval_d     = 1'b0;
      ig_d        = '0;
      shut_d      = 1'b0;
      ans_d       = 1'b0;
    end

    unique case (ctrl_i.op)
      U_BEGIN: begin
        gen_d   = it_q.generation;
        mode_d  = M_WATCH;
        grace_d = 1'b1;
      end
      U_STOP: begin
        mode_d  = M_IDLE;
        grace_d = 1'b0;
      end
      U_SHUT: begin
        if (mode_q == M_WATCH && grace_q) begin
          shut_d  = 1'b1;
          ans_d   = 1'b1;
          mode_d  = M_IDLE;
          grace_d = 1'b0;
        end
      end
      U_STABLE: lst_d = it_q.now_ms;
      U_RCRASH: lct_d = it_q.now_ms;
      U_CHECK: begin
        mode_d  = M_RECON;
        inval_d = 1'b1;
        ig_d    = gen_q;
        if (it_q.now_ms != '0 && lct_q != '0 && lst_q != '0 && stable_ok) begin
          cnt_d = '0;
        end
        if (it_q.now_ms != '0) begin
          lct_d = it_q.now_ms;
        end
      end
      U_BSET_CUR: begin
        v_d = V_W'(cfg_i.base_backoff);
        k_d = cnt_q;
        z_d = cnt_q == '0;
      end
      U_BSET_PREV: begin
        v_d = V_W'(cfg_i.base_backoff);
        k_d = cnt_prev;
        z_d = cnt_prev == '0;
      end
      U_MUL: begin
        if (k_q > CNT_W'(1)) begin
          v_d = v_next;
          k_d = k_q - 1'b1;
        end
      end
      U_CAP: begin
        if (z_q) begin
          b_d = '0;
        end else if (v_q > V_W'(cfg_i.max_backoff)) begin
          b_d = cfg_i.max_backoff;
        end else begin
          b_d = v_q[BO_W-1:0];
        end
      end
      U_QUERY: ans_d = query_ok;
      U_DECIDE: begin
        if (b_q != '0) begin
          mode_d = M_BACKOFF;
          code_d = R_BACKOFF;
        end else if (it_q.restart_ok) begin
          mode_d = M_WATCH;
          code_d = R_RESTARTED;
        end else begin
          mode_d = M_TERM;
          code_d = R_TERMINAL;
        end
      end
      U_INC: begin
        if (cnt_q != COUNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      U_TERM: begin
        mode_d = M_TERM;
        code_d = R_TERMINAL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      cnt_q   <= '0;
      gen_q   <= '0;
      grace_q <= 1'b0;
      lct_q   <= '0;
      lst_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      gen_q   <= gen_d;
      grace_q <= grace_d;
      lct_q   <= lct_d;
      lst_q   <= lst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    v_q     <= v_d;
    k_q     <= k_d;
    z_q     <= z_d;
    b_q     <= b_d;
    code_q  <= code_d;
    inval_q <= inval_d;
    ig_q    <= ig_d;
    shut_q  <= shut_d;
    ans_q   <= ans_d;
  end

endmodule

>>> sv/crash_restart_backoff_supervisor.sv
// Top level of the crash-restart backoff supervisor: stream ports, configuration
// registers and the output register. Depends on crbs_pkg, crbs_useq, crbs_dpath.
//
// The block takes one supervision event per input transaction and returns exactly one
// result transaction for it. An event is taken and then runs a short microprogram;
// every event ends by evaluating the backoff for the current restart count c, with
// the Q8.8 multiplier applied once per count beyond the first in one shared 32x16
// unit. Begin, stop, shutdown, mark-stable and record-crash events evaluate it once.
// A crash check that counts a restart evaluates the backoff twice (before and after
// the increment); a backoff query in the backoff state also evaluates twice. The
// reset budget is five restarts. One event is in progress at a time; s_axis_tready
// is high whenever no event is in progress, also while a finished result still
// waits in the output register. Configuration writes are always accepted and must
// be issued only while no event is in flight; writes to indexes beyond the five
// registers are ignored.
module crash_restart_backoff_supervisor import crbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Event stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // generation [63:0], now_ms [111:64], crashed [112], restart_ok [113], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode [2:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_code [1:0], invalidate [2], invalidated_generation [66:3], do_shutdown [67],
  // answer [68], fsm_state [71:69], restarts_done [79:72], current_backoff [103:80]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  ctrl_t   ctrl;
  stat_t   stat;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    out_busy;

  // Configuration registers; the channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_restarts <= 8'd5;
      cfg_q.base_backoff <= 16'd1000;
      cfg_q.mult_q8      <= 16'd512;
      cfg_q.max_backoff  <= 24'd30000;
      cfg_q.stable_ivl   <= 32'd60000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_RESTARTS: cfg_q.max_restarts <= cfg_data_i[7:0];
        CFG_BASE_BACKOFF: cfg_q.base_backoff <= cfg_data_i[15:0];
        CFG_MULT_Q8:      cfg_q.mult_q8      <= cfg_data_i[15:0];
        CFG_MAX_BACKOFF:  cfg_q.max_backoff  <= cfg_data_i[23:0];
        CFG_STABLE_IVL:   cfg_q.stable_ivl   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Unpack the event transaction.
  assign item.opcode     = s_axis_tuser;
  assign item.generation = s_axis_tdata[63:0];
  assign item.now_ms     = s_axis_tdata[111:64];
  assign item.crashed    = s_axis_tdata[112];
  assign item.restart_ok = s_axis_tdata[113];

  // The output register is busy when it holds a result that is not taken this cycle.
  assign out_busy = out_valid_q && !m_axis_tready;

  crbs_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  crbs_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg_q),
    .item_i (item),
    .stat_o (stat),
    .res_o  (res)
  );

  // Output register: loaded by the final microprogram step, which the sequencer only
  // issues once the previous result has left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == U_FIN) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == U_FIN) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.current_backoff, out_q.restarts_done, out_q.fsm_state,
                          out_q.answer, out_q.do_shutdown, out_q.inv_gen,
                          out_q.invalidate, out_q.code};

`ifndef SYNTHESIS
  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == U_FIN |-> !(out_valid_q && !m_axis_tready))
    else $error("result loaded while output register busy");

  // After an event is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("event accepted while another is in progress");

  // The transient reconciling state is never reported.
  a_no_recon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_q.fsm_state != M_RECON)
    else $error("reconciling state reported");

  // An invalidation always comes with an outcome.
  a_inval_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.invalidate) |-> out_q.code != R_NONE)
    else $error("invalidation without result code");

  // A commanded shutdown is always reported as handled.
  a_shut_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.do_shutdown) |-> out_q.answer)
    else $error("shutdown without answer");
`endif

endmodule

>>> tb/tb_crash_restart_backoff_supervisor.sv
// Self-checking testbench for the crash-restart backoff supervisor.
// Drives supervision events and register writes and checks every result against a
// behavioral predictor kept here. Depends on crbs_pkg and the supervisor RTL.
`timescale 1ns / 1ps

module tb_crash_restart_backoff_supervisor;
  import crbs_pkg::*;

  // One supervision event as the sender sees it, before packing onto the stream.
  typedef struct {
    opcode_e          op;
    logic [GEN_W-1:0] gen;
    logic [NOW_W-1:0] now;
    logic             crashed;
    logic             restart_ok;
  } sup_event_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // Predictor copy of the configuration registers and of the supervisor state.
  cfg_t              limits;
  mode_e             sup_mode;
  logic [CNT_W-1:0]  restarts;
  logic [GEN_W-1:0]  watched;
  logic              grace;
  logic [NOW_W-1:0]  crash_time;
  logic [NOW_W-1:0]  stable_time;

  // Results predicted for accepted events, oldest first.
  result_t           expected_q[$];
  int unsigned       errors;
  // Set while a stretch without any idle cycles on either side is wanted.
  bit                no_gaps;
  // A nonzero value asks the result sink to hold m_axis_tready low that many cycles.
  int unsigned       rx_hold_req;
  // Running wall clock used to build plausible event times.
  logic [NOW_W-1:0]  wall_ms;

  crash_restart_backoff_supervisor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(50_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Capped exponential backoff for a restart count: the base is scaled by the Q8.8
  // multiplier once per count beyond the first, truncating, saturating at 32 bits.
  function automatic logic [31:0] backoff_ms(logic [CNT_W-1:0] count);
    logic [63:0] v;
    if (count == '0) return '0;
    v = limits.base_backoff;
    for (int i = 1; i < count; i++) begin
      v = (v * limits.mult_q8) >> Q_FRAC;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    end
    if (v > limits.max_backoff) v = limits.max_backoff;
    return v[31:0];
  endfunction

  // A time that went backwards never counts as elapsed.
  function automatic bit has_elapsed(logic [NOW_W-1:0] now, logic [NOW_W-1:0] since,
                                     logic [NOW_W-1:0] span);
    if (now < since) return 1'b0;
    return (now - since) >= span;
  endfunction

  // Applies one event to the predicted state and returns the result it produces.
  function automatic result_t supervise_step(sup_event_t ev);
    result_t          r;
    logic [31:0]      b;
    logic [NOW_W-1:0] now;
    r   = '0;
    now = ev.now & TIME_MASK;
    case (ev.op)
      OP_BEGIN: begin
        watched  = ev.gen;
        sup_mode = M_WATCH;
        grace    = 1'b1;
      end
      OP_STOP: begin
        sup_mode = M_IDLE;
        grace    = 1'b0;
      end
      OP_CHECK: begin
        if (sup_mode == M_WATCH && ev.crashed) begin
          r.invalidate = 1'b1;
          r.inv_gen    = watched;
          // A long enough stable run forgives earlier restarts, but only when every
          // time involved is known.
          if (now != '0 && crash_time != '0 && stable_time != '0 &&
              has_elapsed(now, stable_time, limits.stable_ivl)) restarts = '0;
          if (now != '0) crash_time = now;
          if (restarts >= limits.max_restarts) begin
            sup_mode = M_TERM;
            r.code   = R_TERMINAL;
          end else begin
            b = backoff_ms(restarts);
            if (restarts < COUNT_MAX) restarts++;
            if (b != '0) begin
              sup_mode = M_BACKOFF;
              r.code   = R_BACKOFF;
            end else if (ev.restart_ok) begin
              sup_mode = M_WATCH;
              r.code   = R_RESTARTED;
            end else begin
              sup_mode = M_TERM;
              r.code   = R_TERMINAL;
            end
          end
        end
      end
      OP_SHUTDOWN: begin
        if (sup_mode == M_WATCH && grace) begin
          r.do_shutdown = 1'b1;
          r.answer      = 1'b1;
          sup_mode      = M_IDLE;
          grace         = 1'b0;
        end
      end
      OP_STABLE: stable_time = now;
      OP_CRASH:  crash_time = now;
      OP_QUERY: begin
        if (sup_mode == M_BACKOFF) begin
          b = (restarts == '0) ? '0 : backoff_ms(restarts - 1'b1);
          r.answer = has_elapsed(now, crash_time, b);
        end
      end
      default: ;
    endcase
    b = backoff_ms(restarts);
    r.fsm_state       = sup_mode;
    r.restarts_done   = restarts;
    r.current_backoff = b[BO_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sup_event_t make_event(opcode_e op, logic [GEN_W-1:0] gen,
                                            logic [NOW_W-1:0] now, logic crashed,
                                            logic restart_ok);
    sup_event_t ev;
    ev.op         = op;
    ev.gen        = gen;
    ev.now        = now;
    ev.crashed    = crashed;
    ev.restart_ok = restart_ok;
    return ev;
  endfunction

  // Moves the wall clock on and returns a time for the next event. Now and then the
  // time is unknown, goes backwards, or jumps across the stable interval boundary.
  function automatic logic [NOW_W-1:0] advance_clock();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return wall_ms - $urandom_range(5000);
    if (roll < 16) wall_ms = wall_ms + limits.stable_ivl + $urandom_range(2) - 48'd1;
    else wall_ms = wall_ms + $urandom_range(40000);
    return wall_ms;
  endfunction

  // Offers one event and predicts its result once the transaction is accepted. The
  // valid stays high afterwards so that the next event can follow back to back.
  task automatic send_event(sup_event_t ev);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.op;
    s_axis_tdata  <= IN_TDATA_W'({ev.restart_ok, ev.crashed, ev.now, ev.gen});
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(supervise_step(ev));
  endtask

  // Drops the event stream and waits until every predicted result has been checked.
  // All events produce a result, so a short pause afterwards is enough.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_RESTARTS: limits.max_restarts = value[7:0];
      CFG_BASE_BACKOFF: limits.base_backoff = value[15:0];
      CFG_MULT_Q8:      limits.mult_q8      = value[15:0];
      CFG_MAX_BACKOFF:  limits.max_backoff  = value[23:0];
      CFG_STABLE_IVL:   limits.stable_ivl   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers are only rewritten with no event in flight.
  task automatic set_limits(logic [31:0] budget, logic [31:0] base, logic [31:0] mult,
                            logic [31:0] cap, logic [31:0] stable_ivl);
    wait_idle();
    write_reg(CFG_MAX_RESTARTS, budget);
    write_reg(CFG_BASE_BACKOFF, base);
    write_reg(CFG_MULT_Q8, mult);
    write_reg(CFG_MAX_BACKOFF, cap);
    write_reg(CFG_STABLE_IVL, stable_ivl);
  endtask

  // Mostly well-formed supervision traffic chosen from the predicted state, so that
  // crashes, backoffs and queries near the backoff deadline come up often, mixed with
  // fully random events.
  task automatic random_session(int unsigned n_events);
    sup_event_t  ev;
    int unsigned pick;
    repeat (n_events) begin
      pick = $urandom_range(99);
      ev = make_event(OP_NONE, {$urandom, $urandom}, advance_clock(),
                      $urandom_range(99) < 90, $urandom_range(99) < 85);
      if (pick < 12) begin
        ev.op         = opcode_e'($urandom_range(7));
        ev.now        = NOW_W'({$urandom, $urandom});
        ev.crashed    = $urandom_range(1);
        ev.restart_ok = $urandom_range(1);
      end else begin
        case (sup_mode)
          M_WATCH:
            ev.op = (pick < 60) ? OP_CHECK : (pick < 68) ? OP_SHUTDOWN :
                    (pick < 80) ? OP_STABLE : (pick < 86) ? OP_CRASH :
                    (pick < 93) ? OP_QUERY : OP_STOP;
          M_BACKOFF: begin
            if (pick < 65) begin
              // Land one below, on, or one past the deadline of the current backoff.
              ev.op  = OP_QUERY;
              ev.now = crash_time + backoff_ms(restarts - 1'b1) + $urandom_range(2) - 48'd1;
            end else begin
              ev.op = (pick < 92) ? OP_BEGIN : OP_STOP;
            end
          end
          default:
            ev.op = (pick < 80) ? OP_BEGIN : (pick < 88) ? OP_STABLE :
                    (pick < 94) ? OP_CRASH : OP_QUERY;
        endcase
      end
      send_event(ev);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walks through every event kind with the reset configuration: events outside their
  // state, shutdown inside the startup grace, restarts with unknown time, queries
  // before and on the deadline and with time running backwards, the stable reset,
  // a failed immediate restart, restart from terminal, and a spent budget.
  task automatic test_directed_events();
    send_event(make_event(OP_QUERY, '0, 48'd5, 1'b0, 1'b0));
    send_event(make_event(OP_SHUTDOWN, '0, 48'd6, 1'b0, 1'b0));
    send_event(make_event(OP_CHECK, '0, 48'd7, 1'b1, 1'b1));
    send_event(make_event(OP_NONE, '1, '1, 1'b1, 1'b1));
    send_event(make_event(OP_BEGIN, '1, '0, 1'b0, 1'b0));
    send_event(make_event(OP_SHUTDOWN, '0, 48'd10, 1'b0, 1'b0));
    send_event(make_event(OP_BEGIN, 64'h0123_4567_89ab_cdef, 48'd20, 1'b0, 1'b0));
    send_event(make_event(OP_CHECK, '0, 48'd30, 1'b0, 1'b1));
    send_event(make_event(OP_CHECK, '0, '0, 1'b1, 1'b1));
    send_event(make_event(OP_CHECK, '0, 48'd1000, 1'b1, 1'b1));
    send_event(make_event(OP_QUERY, '0, 48'd500, 1'b0, 1'b0));
    send_event(make_event(OP_QUERY, '0, 48'd1999, 1'b0, 1'b0));
    send_event(make_event(OP_QUERY, '0, 48'd2000, 1'b0, 1'b0));
    send_event(make_event(OP_SHUTDOWN, '0, 48'd2100, 1'b0, 1'b0));
    send_event(make_event(OP_STABLE, '0, 48'd3000, 1'b0, 1'b0));
    send_event(make_event(OP_BEGIN, 64'h5, 48'd3100, 1'b0, 1'b0));
    send_event(make_event(OP_CHECK, '0, 48'd63000, 1'b1, 1'b0));
    send_event(make_event(OP_BEGIN, 64'h6, 48'd63100, 1'b0, 1'b0));
    send_event(make_event(OP_STOP, '0, 48'd63200, 1'b0, 1'b0));
    send_event(make_event(OP_BEGIN, 64'h8000_0000_0000_0000, 48'd63300, 1'b0, 1'b0));
    send_event(make_event(OP_CRASH, '0, '1, 1'b0, 1'b0));
    send_event(make_event(OP_STABLE, '0, '1, 1'b0, 1'b0));
    // The stable time now lies ahead, so the count only climbs until it is spent.
    repeat (5) begin
      send_event(make_event(OP_CHECK, '0, 48'd100, 1'b1, 1'b1));
      send_event(make_event(OP_BEGIN, 64'h9, 48'd200, 1'b0, 1'b0));
    end
  endtask

  // With no backoff every crash restarts at once, so the count climbs to its
  // saturation value and the largest budget is spent on the next crash.
  task automatic test_count_saturation();
    set_limits(32'd255, 32'd0, 32'd512, 32'd1000, 32'hFFFF_FFFF);
    send_event(make_event(OP_BEGIN, 64'hA5A5_5A5A_0F0F_F0F0, '0, 1'b0, 1'b0));
    while (sup_mode != M_TERM)
      send_event(make_event(OP_CHECK, '0, '0, 1'b1, 1'b1));
    send_event(make_event(OP_CHECK, '0, '0, 1'b1, 1'b1));
    send_event(make_event(OP_BEGIN, 64'h1, '0, 1'b0, 1'b0));
    send_event(make_event(OP_CHECK, '0, '0, 1'b1, 1'b1));
  endtask

  // Random traffic under several register settings, the extremes among them.
  task automatic test_config_sweep();
    set_limits(32'd5, 32'd1000, 32'd512, 32'd30000, 32'd60000);
    random_session(110);
    set_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_session(110);
    set_limits(32'd255, 32'd65535, 32'd65535, 32'hFF_FFFF, 32'hFFFF_FFFF);
    random_session(110);
    set_limits(32'd3, 32'd1, 32'd256, 32'd100, 32'd1000);
    random_session(110);
    set_limits(32'd12, 32'd0, 32'd384, 32'd5000, 32'd50);
    random_session(110);
    set_limits($urandom_range(255), $urandom_range(65535), $urandom_range(65535),
               $urandom_range(24'hFF_FFFF), $urandom_range(200000));
    random_session(110);
  endtask

  // The result sink stops for a long stretch while events keep coming, so the output
  // register fills, the next event stalls at its end and the input is held off.
  task automatic test_output_stall();
    set_limits(32'd6, 32'd700, 32'd640, 32'd20000, 32'd90000);
    rx_hold_req = 300;
    random_session(40);
  endtask

  // Back-to-back transactions on both sides with no idle cycles at all.
  task automatic test_back_to_back();
    wait_idle();
    no_gaps = 1'b1;
    random_session(120);
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.code            = res_code_e'(m_axis_tdata[1:0]);
      got.invalidate      = m_axis_tdata[2];
      got.inv_gen         = m_axis_tdata[66:3];
      got.do_shutdown     = m_axis_tdata[67];
      got.answer          = m_axis_tdata[68];
      got.fsm_state       = mode_e'(m_axis_tdata[71:69]);
      got.restarts_done   = m_axis_tdata[79:72];
      got.current_backoff = m_axis_tdata[103:80];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result expected none, got 0x%0h", $time, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("result_code", want.code, got.code);
        check_field("invalidate", want.invalidate, got.invalidate);
        check_field("invalidated_generation", want.inv_gen, got.inv_gen);
        check_field("do_shutdown", want.do_shutdown, got.do_shutdown);
        check_field("answer", want.answer, got.answer);
        check_field("fsm_state", want.fsm_state, got.fsm_state);
        check_field("restarts_done", want.restarts_done, got.restarts_done);
        check_field("current_backoff", want.current_backoff, got.current_backoff);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Inputs are known from time zero; the reset values of the registers and of the
    // supervisor state are mirrored in the predictor.
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BEGIN;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MAX_RESTARTS;
    cfg_data_i    = '0;
    limits        = '{8'd5, 16'd1000, 16'd512, 24'd30000, 32'd60000};
    sup_mode      = M_IDLE;
    restarts      = '0;
    watched       = '0;
    grace         = 1'b0;
    crash_time    = '0;
    stable_time   = '0;
    errors        = 0;
    no_gaps       = 1'b0;
    rx_hold_req   = 0;
    wall_ms       = 48'd1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_events();
    test_count_saturation();
    test_config_sweep();
    test_output_stall();
    test_back_to_back();

    // Drain what is left, then leave room for the slowest event to show up late.
    wait_idle();
    repeat (600) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
